### src/mcr_pkg.sv
// ============================================================================
// mcr_pkg - shared constants for the midpoint circle rasterizer
// default widths, queue depth and command kind codes
// ============================================================================
package mcr_pkg;

  // default field widths
  localparam int RADIUS_BITS_DEF = 12;
  localparam int COORD_BITS_DEF  = 16;

  // command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // request types on the input channel
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // command kinds handed from front to back
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_ZERO  = 3'd0;  // single center point
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;  // four axis points
  localparam logic [KIND_W-1:0] KIND_OCT4  = 3'd2;  // four diagonal points
  localparam logic [KIND_W-1:0] KIND_OCT8  = 3'd3;  // eight octant points
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;  // done marker, no point

  // reflection index width (up to eight results per command)
  localparam int REFL_W = 3;

endpackage

### src/midpoint_circle_rasterizer.sv
// ============================================================================
// midpoint_circle_rasterizer - midpoint circle perimeter generator
// start loads center and radius, each advance walks one midpoint step
// ============================================================================
// A start request (tuser = 0) latches the center and radius and yields the
// axis pixels: one pixel for radius zero, else four. Each advance request
// (tuser = 1) takes one midpoint step in the first octant and yields four
// pixels on the diagonal or eight otherwise; an advance that ends the circle,
// or comes with no circle in progress, yields one result with done set and no
// pixel. The last result of each request carries tlast. Requests are taken
// one per cycle into a two-entry command queue while it has room, so a new
// request is accepted while earlier pixels are still being sent. Pixels leave
// at one per cycle while m_tready is high, so a start yields 1 or 4 results
// and an advance 1, 4 or 8; the output side sets the sustained rate.
// ============================================================================
module midpoint_circle_rasterizer #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // center_x, center_y, radius, zero pad
  input  logic [((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                  s_tuser,   // req_type
  // result channel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // point_x, point_y, zero pad
  output logic [((2 * COORD_BITS + 9) / 8) * 8 - 1:0] m_tdata,
  output logic [1:0]            m_tuser,   // has_point, done_res
  output logic                  m_tlast    // last result of the request
);

  localparam int IN_BITS    = 2 * COORD_BITS + RADIUS_BITS;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * (COORD_BITS + 1);
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int CMD_W      = mcr_pkg::KIND_W + 2 * COORD_BITS + 2 * RADIUS_BITS;

  // front to queue
  logic             f_valid;
  logic             f_ready;
  logic [CMD_W-1:0] f_cmd;
  // queue to back
  logic             q_valid;
  logic             q_ready;
  logic [CMD_W-1:0] q_cmd;

  logic signed [COORD_BITS:0] point_x;
  logic signed [COORD_BITS:0] point_y;
  logic                       has_point;
  logic                       done_res;

  // request decode and midpoint stepping
  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (s_tuser),
    .center_x  (s_tdata[COORD_BITS-1:0]),
    .center_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius    (s_tdata[IN_BITS-1:2*COORD_BITS]),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // commands wait here while the emitter is busy
  mcr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (mcr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // reflection and output register
  mcr_back #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .point_x   (point_x),
    .point_y   (point_y),
    .has_point (has_point),
    .last      (m_tlast),
    .done_res  (done_res)
  );

  // pack the result fields, x in the low bits
  assign m_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, point_y, point_x};
  assign m_tuser = {done_res, has_point};

endmodule

### src/mcr_front.sv
// ============================================================================
// mcr_front - request decoder and midpoint stepper
// holds the octant point and decision variable, turns each request into
// one command for the emit side
// ============================================================================
module mcr_front #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int CMD_W       = mcr_pkg::KIND_W + 2 * COORD_BITS + 2 * RADIUS_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic        [RADIUS_BITS-1:0] radius,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output logic        [CMD_W-1:0]       cmd
);

  localparam int DEC_W = RADIUS_BITS + 3;

  typedef struct packed {
    logic [mcr_pkg::KIND_W-1:0] kind;
    logic [COORD_BITS-1:0]      cx;
    logic [COORD_BITS-1:0]      cy;
    logic [RADIUS_BITS-1:0]     px;
    logic [RADIUS_BITS-1:0]     py;
  } cmd_t;

  logic [RADIUS_BITS-1:0] cur_x, cur_x_next;
  logic [RADIUS_BITS-1:0] cur_y, cur_y_next;
  logic [DEC_W-1:0]       decision, decision_next;
  logic [COORD_BITS-1:0]  held_center_x, held_center_x_next;
  logic [COORD_BITS-1:0]  held_center_y, held_center_y_next;
  logic                   active, active_next;

  logic                   accept;
  logic [RADIUS_BITS-1:0] y_inc;
  logic [RADIUS_BITS-1:0] x_dec;
  logic [RADIUS_BITS-1:0] x_step;
  logic [DEC_W-1:0]       two_y_inc;
  logic [DEC_W-1:0]       two_x_dec;
  logic                   dec_pos;
  cmd_t                   cmd_s;

  assign accept    = in_valid && cmd_ready;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign cmd       = cmd_s;

  assign y_inc     = cur_y + RADIUS_BITS'(1);
  assign x_dec     = cur_x - RADIUS_BITS'(1);
  assign two_y_inc = {{(DEC_W - RADIUS_BITS - 1){1'b0}}, y_inc, 1'b1};
  assign two_x_dec = {{(DEC_W - RADIUS_BITS - 1){1'b0}}, x_dec, 1'b0};
  assign dec_pos   = !decision[DEC_W-1] && (decision != '0);
  assign x_step    = dec_pos ? x_dec : cur_x;

  always_comb begin
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    decision_next      = decision;
    held_center_x_next = held_center_x;
    held_center_y_next = held_center_y;
    active_next        = active;
    cmd_s.kind = mcr_pkg::KIND_DONE;
    cmd_s.cx   = held_center_x;
    cmd_s.cy   = held_center_y;
    cmd_s.px   = cur_x;
    cmd_s.py   = cur_y;
    if (req_type == mcr_pkg::REQ_START) begin
      held_center_x_next = center_x;
      held_center_y_next = center_y;
      cur_x_next         = radius;
      cur_y_next         = '0;
      decision_next      = DEC_W'(1) - {{(DEC_W - RADIUS_BITS){1'b0}}, radius};
      active_next        = (radius != '0);
      cmd_s.kind = (radius == '0) ? mcr_pkg::KIND_ZERO : mcr_pkg::KIND_START;
      cmd_s.cx   = center_x;
      cmd_s.cy   = center_y;
      cmd_s.px   = radius;
      cmd_s.py   = '0;
    end else if (!active || (cur_x <= cur_y)) begin
      active_next = 1'b0;
    end else begin
      cur_x_next    = x_step;
      cur_y_next    = y_inc;
      decision_next = dec_pos ? decision + two_y_inc - two_x_dec
                              : decision + two_y_inc;
      cmd_s.px = x_step;
      cmd_s.py = y_inc;
      if (x_step < y_inc) begin
        active_next = 1'b0;
      end else if (x_step == y_inc) begin
        cmd_s.kind = mcr_pkg::KIND_OCT4;
      end else begin
        cmd_s.kind = mcr_pkg::KIND_OCT8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      decision      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      cur_x         <= cur_x_next;
      cur_y         <= cur_y_next;
      decision      <= decision_next;
      held_center_x <= held_center_x_next;
      held_center_y <= held_center_y_next;
      active        <= active_next;
    end
  end

endmodule

### src/mcr_queue.sv
// ============================================================================
// mcr_queue - small command fifo
// decouples the stepper from the emit side
// ============================================================================
module mcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### src/mcr_back.sv
// ============================================================================
// mcr_back - point emitter
// expands one command into its reflected pixels, one per cycle while the
// output is not stalled, through a registered output stage
// ============================================================================
module mcr_back #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int CMD_W       = mcr_pkg::KIND_W + 2 * COORD_BITS + 2 * RADIUS_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  logic [CMD_W-1:0]            cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_BITS:0]  point_x,
  output logic signed [COORD_BITS:0]  point_y,
  output logic                        has_point,
  output logic                        last,
  output logic                        done_res
);

  localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  typedef struct packed {
    logic [mcr_pkg::KIND_W-1:0] kind;
    logic [COORD_BITS-1:0]      cx;
    logic [COORD_BITS-1:0]      cy;
    logic [RADIUS_BITS-1:0]     px;
    logic [RADIUS_BITS-1:0]     py;
  } cmd_t;

  cmd_t                      cur;
  logic                      busy;
  logic [mcr_pkg::REFL_W-1:0] refl, refl_next;
  logic                      load;
  logic                      is_last;
  logic                      is_done;
  logic [RADIUS_BITS-1:0]    off_a;
  logic [RADIUS_BITS-1:0]    off_b;
  logic signed [SUM_W-1:0]   cx_e, cy_e, a_e, b_e, sum_x, sum_y;

  assign load      = busy && (!out_valid || out_ready);
  assign cmd_ready = !busy || (load && is_last);
  assign is_done   = (cur.kind == mcr_pkg::KIND_DONE);

  // last reflection of each kind, and the order it walks
  always_comb begin
    is_last   = 1'b1;
    refl_next = refl + mcr_pkg::REFL_W'(1);
    case (cur.kind)
      mcr_pkg::KIND_START: begin
        // axis points map onto reflections 0, 1, 4, 6 with y at zero
        is_last = (refl == mcr_pkg::REFL_W'(6));
        if (refl == mcr_pkg::REFL_W'(1)) begin
          refl_next = mcr_pkg::REFL_W'(4);
        end else if (refl == mcr_pkg::REFL_W'(4)) begin
          refl_next = mcr_pkg::REFL_W'(6);
        end
      end
      mcr_pkg::KIND_OCT4: is_last = (refl == mcr_pkg::REFL_W'(3));
      mcr_pkg::KIND_OCT8: is_last = (refl == mcr_pkg::REFL_W'(7));
      default:            is_last = 1'b1;
    endcase
  end

  // bit 2 swaps the axes, bit 0 negates x offset, bit 1 negates y offset
  assign off_a = refl[2] ? cur.py : cur.px;
  assign off_b = refl[2] ? cur.px : cur.py;
  assign cx_e  = {{(SUM_W - COORD_BITS){cur.cx[COORD_BITS-1]}}, cur.cx};
  assign cy_e  = {{(SUM_W - COORD_BITS){cur.cy[COORD_BITS-1]}}, cur.cy};
  assign a_e   = {{(SUM_W - RADIUS_BITS){1'b0}}, off_a};
  assign b_e   = {{(SUM_W - RADIUS_BITS){1'b0}}, off_b};
  assign sum_x = refl[0] ? cx_e - a_e : cx_e + a_e;
  assign sum_y = refl[1] ? cy_e - b_e : cy_e + b_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      refl      <= '0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        busy <= 1'b1;
        refl <= '0;
      end else if (load) begin
        busy <= !is_last;
        refl <= refl_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur <= cmd;
    end
    if (load) begin
      point_x   <= is_done ? '0 : sum_x[COORD_BITS:0];
      point_y   <= is_done ? '0 : sum_y[COORD_BITS:0];
      has_point <= !is_done;
      done_res  <= is_done;
      last      <= is_last;
    end
  end

endmodule

### src/mcr_checker.sv
// ============================================================================
// mcr_checker - port level checks for the circle rasterizer
// watches the result channel for consistent result flags, zeroed done coordinates and stall holding
// ============================================================================
module mcr_checker #(
  parameter int OUT_DATA_W = 40
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast
);

  // a done result ends its request and carries no pixel
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
    else $error("done result without tlast or with a pixel");

  // every result is either a pixel or a done marker
  a_pixel_or_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tuser[1])
    else $error("result carries neither pixel nor done");

  // done results have zeroed coordinates
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '0)
    else $error("done result with nonzero coordinates");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind midpoint_circle_rasterizer mcr_checker #(
  .OUT_DATA_W (OUT_DATA_W)
) u_mcr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
